>>> rtl/irt_pkg.sv
// irt_pkg: types, status codes and default sizes for the interval reservation table.
// No dependencies; imported by every module of the block.
package irt_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int TIME_BITS_DEF = 32;
   localparam int PORT_TIME_W   = 32;

   typedef enum logic [1:0] {
      ST_GRANTED = 2'd0,
      ST_OVERLAP = 2'd1,
      ST_FULL    = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_DECIDE
   } state_type;

   typedef struct packed {
      logic capture;
      logic shift;
   } cell_ctl_type;

endpackage

>>> rtl/irt_cell.sv
// irt_cell: one slot of the reservation chain; holds an interval, checks it against
// the incoming request and hands its interval to the next slot on a grant. Uses irt_pkg.
module irt_cell #(
   parameter int INDEX     = 0,
   parameter int CAPACITY  = irt_pkg::CAPACITY_DEF,
   parameter int TIME_BITS = irt_pkg::TIME_BITS_DEF,
   parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  irt_pkg::cell_ctl_type ctl,
   input  logic [CNT_W-1:0]      count,
   input  logic [TIME_BITS-1:0]  req_start,
   input  logic [TIME_BITS-1:0]  req_end,
   input  logic [TIME_BITS-1:0]  shift_start,
   input  logic [TIME_BITS-1:0]  shift_end,
   output logic [TIME_BITS-1:0]  entry_start,
   output logic [TIME_BITS-1:0]  entry_end,
   output logic                  hit
);
   import irt_pkg::*;

   logic [TIME_BITS-1:0] start_ff;
   logic [TIME_BITS-1:0] end_ff;
   logic                 hit_ff;
   logic                 hit_in;
   logic                 occupied;

   assign occupied = CNT_W'(INDEX) < count;
   assign hit_in   = occupied && (req_start < end_ff) && (start_ff < req_end);

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         start_ff <= shift_start;
         end_ff   <= shift_end;
      end
      if (ctl.capture) begin
         hit_ff <= hit_in;
      end
   end

   assign entry_start = start_ff;
   assign entry_end   = end_ff;
   assign hit         = hit_ff;

endmodule

>>> rtl/interval_reservation_table_unit.sv
// interval_reservation_table_unit: top level; chain of irt_cell slots, fill count,
// decision sequencer and result register. Uses irt_pkg and irt_cell.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_start_time, req_end_time
//   rsp      out  rsp_valid/rsp_stall  rsp_status, rsp_granted
//
// Every slot compares in the accept cycle and registers its hit; the OR of slot hits and
// the grant are resolved in the decide state, in which req_stall is high (no new beat
// is taken). Reset empties the table by clearing the fill count; slot contents are not
// cleared. A stalled result holds the decide state until the result register frees.
module interval_reservation_table_unit #(
   parameter int CAPACITY  = irt_pkg::CAPACITY_DEF,
   parameter int TIME_BITS = irt_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [irt_pkg::PORT_TIME_W-1:0] req_start_time,
   input  logic [irt_pkg::PORT_TIME_W-1:0] req_end_time,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_granted
);
   import irt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TIME_BITS-1:0] start_ff, end_ff;
   logic                 invalid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic                 rsp_granted_ff;

   logic [TIME_BITS-1:0] s_req, e_req;
   logic                 req_take;
   logic                 fire;
   logic                 any_hit;
   status_type           status;
   cell_ctl_type         ctl;
   logic [CAPACITY-1:0]  hit_vec;
   logic [TIME_BITS-1:0] cell_start [CAPACITY];
   logic [TIME_BITS-1:0] cell_end   [CAPACITY];

   assign s_req = TIME_BITS'(req_start_time);
   assign e_req = TIME_BITS'(req_end_time);

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign fire      = (state_ff == S_DECIDE) && (!rsp_valid_ff || !rsp_stall);
   assign any_hit   = |hit_vec;

   always_comb begin
      priority if (invalid_ff) begin
         status = ST_INVALID;
      end else if (any_hit) begin
         status = ST_OVERLAP;
      end else if (count_ff == CNT_W'(CAPACITY)) begin
         status = ST_FULL;
      end else begin
         status = ST_GRANTED;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_take) state_in = S_DECIDE;
         S_DECIDE: if (fire) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl.capture  = req_take;
      ctl.shift    = fire && (status == ST_GRANTED);
      count_in     = ctl.shift ? count_ff + CNT_W'(1) : count_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         start_ff   <= s_req;
         end_ff     <= e_req;
         invalid_ff <= (e_req <= s_req);
      end
      if (fire) begin
         rsp_status_ff  <= status;
         rsp_granted_ff <= (status == ST_GRANTED);
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [TIME_BITS-1:0] sh_start, sh_end;
      if (i == 0) begin : g_head
         assign sh_start = start_ff;
         assign sh_end   = end_ff;
      end else begin : g_link
         assign sh_start = cell_start[i-1];
         assign sh_end   = cell_end[i-1];
      end
      irt_cell #(
         .INDEX(i), .CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS), .CNT_W(CNT_W)
      ) u_cell (
         .clock(clock),
         .ctl(ctl),
         .count(count_ff),
         .req_start(s_req),
         .req_end(e_req),
         .shift_start(sh_start),
         .shift_end(sh_end),
         .entry_start(cell_start[i]),
         .entry_end(cell_end[i]),
         .hit(hit_vec[i])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_granted = rsp_granted_ff;

endmodule

>>> rtl/irt_checker.sv
// irt_checker: port-level assertions for interval_reservation_table_unit, with bind.
// Uses irt_pkg.
module irt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic       rsp_granted
);
   import irt_pkg::*;

   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_granted_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_granted == (rsp_status == ST_GRANTED)))
      else $error("rsp_granted disagrees with rsp_status");

   a_busy_after_beat : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while decision pending");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_granted)))
      else $error("stalled result changed");

endmodule

bind interval_reservation_table_unit irt_checker u_irt_checker (.*);

>>> sim/testbench.sv
// testbench: self-checking bench for interval_reservation_table_unit.
// A directed table, then random beats, are checked against an in-bench model of
// the reservation table. Depends on rtl/irt_pkg.sv and the unit under test.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import irt_pkg::*;

   localparam int TW = PORT_TIME_W;
   localparam logic [TW-1:0] TIME_MAX = '1;
   localparam int RANDOM_BEATS = 1500;
   localparam int QUIET_TAIL = 200;

   typedef struct packed {
      logic [TW-1:0] start_time;
      logic [TW-1:0] end_time;
      logic          known;
      status_type    status;
   } request_row_type;

   typedef struct packed {
      status_type status;
      logic       granted;
   } decision_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [TW-1:0] req_start_time = '0;
   logic [TW-1:0] req_end_time = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [1:0]    rsp_status;
   logic          rsp_granted;

   logic [TW-1:0] booked_start [CAPACITY_DEF];
   logic [TW-1:0] booked_end [CAPACITY_DEF];
   int            booked_count = 0;

   decision_type  awaited_decisions [$];
   int            error_count = 0;
   logic          idling_on = 1'b1;
   int            stall_left = 0;

   // rows marked known carry a fixed expected status used in place of the model's prediction
   request_row_type directed_rows [20] = '{
      '{32'd0,          32'd0,          1'b1, ST_INVALID},
      '{TIME_MAX,       TIME_MAX,       1'b1, ST_INVALID},
      '{TIME_MAX,       32'd0,          1'b1, ST_INVALID},
      '{32'd5,          32'd4,          1'b1, ST_INVALID},
      '{32'd0,          32'd10,         1'b1, ST_GRANTED},
      '{32'd0,          32'd10,         1'b1, ST_OVERLAP},
      '{32'd10,         32'd20,         1'b0, ST_GRANTED},
      '{32'd9,          32'd11,         1'b0, ST_GRANTED},
      '{32'd30,         32'd40,         1'b0, ST_GRANTED},
      '{32'd25,         32'd45,         1'b0, ST_GRANTED},
      '{32'd32,         32'd35,         1'b0, ST_GRANTED},
      '{32'd20,         32'd30,         1'b0, ST_GRANTED},
      '{TIME_MAX - 1,   TIME_MAX,       1'b0, ST_GRANTED},
      '{32'd0,          TIME_MAX,       1'b0, ST_GRANTED},
      '{TIME_MAX - 2,   TIME_MAX - 1,   1'b0, ST_GRANTED},
      '{32'd40,         32'd41,         1'b0, ST_GRANTED},
      '{32'd40,         32'd40,         1'b1, ST_INVALID},
      '{32'd41,         32'd0,          1'b1, ST_INVALID},
      '{32'h8000_0000,  32'h8000_0001,  1'b0, ST_GRANTED},
      '{32'd1,          32'd2,          1'b0, ST_GRANTED}
   };

   interval_reservation_table_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_granted    (rsp_granted)
   );

   always #5 clock = ~clock;

   // reject empty or inverted, then half-open overlap check against every booked slot; book on a clean miss unless full
   function automatic status_type reserve_interval(input logic [TW-1:0] s,
                                                   input logic [TW-1:0] e);
      if (e <= s) begin
         return ST_INVALID;
      end
      for (int i = 0; i < booked_count; i++) begin
         if (s < booked_end[i] && booked_start[i] < e) begin
            return ST_OVERLAP;
         end
      end
      if (booked_count >= CAPACITY_DEF) begin
         return ST_FULL;
      end
      booked_start[booked_count] = s;
      booked_end[booked_count] = e;
      booked_count++;
      return ST_GRANTED;
   endfunction

   // probes around booked edges most often, with fresh, inverted or empty and raw beats mixed in
   task automatic pick_random_interval(output logic [TW-1:0] s, output logic [TW-1:0] e);
      int            pick;
      int            slot;
      logic [TW-1:0] os;
      logic [TW-1:0] oe;
      logic [TW-1:0] len;
      pick = $urandom_range(0, 99);
      len = $urandom_range(1, 8);
      s = $urandom;
      e = $urandom;
      if (pick < 45 && booked_count > 0) begin
         slot = $urandom_range(0, booked_count - 1);
         os = booked_start[slot];
         oe = booked_end[slot];
         case ($urandom_range(0, 6))
            0: begin s = oe;       e = oe + len; end
            1: begin s = os - len; e = os;       end
            2: begin s = oe - 1;   e = oe - 1 + len; end
            3: begin s = os - len; e = os + 1;   end
            4: begin s = os - 1;   e = oe + 1;   end
            5: begin s = os;       e = oe;       end
            default: begin s = os; e = os + 1;  end
         endcase
      end else if (pick < 60) begin
         e = s + ($urandom_range(1, 255) << $urandom_range(0, 20));
      end else if (pick < 75) begin
         e = ($urandom_range(0, 3) == 0) ? s : s - $urandom_range(1, 1000);
      end
   endtask

   task automatic send_request(input logic [TW-1:0] s, input logic [TW-1:0] e,
                               input logic known, input status_type typed);
      status_type   predicted;
      decision_type want;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_time <= s;
      req_end_time <= e;
      do @(posedge clock); while (req_stall);
      predicted = reserve_interval(s, e);
      want.status = known ? typed : predicted;
      want.granted = (want.status == ST_GRANTED);
      awaited_decisions = {awaited_decisions, want};
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_decisions.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 14);
      end
      rsp_stall <= idling_on && !reset && stall_left != 0;
   end

   always @(posedge clock) begin
      decision_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_decisions.size() == 0) begin
            $display("%0t: result beat expected none actual status=%0d granted=%0b",
                     $time, rsp_status, rsp_granted);
            error_count++;
         end else begin
            want = awaited_decisions.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_granted !== want.granted) begin
               $display("%0t: granted expected %0b actual %0b",
                        $time, want.granted, rsp_granted);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [TW-1:0] s;
      logic [TW-1:0] e;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].start_time, directed_rows[i].end_time,
                      directed_rows[i].known, directed_rows[i].status);
      end
      drain_results();
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         idling_on = (n < RANDOM_BEATS - QUIET_TAIL) && ((n / 150) % 4 != 3);
         if (n == RANDOM_BEATS / 2) begin
            drain_results();
         end
         pick_random_interval(s, e);
         send_request(s, e, 1'b0, ST_GRANTED);
      end
      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
